// File: rtl/positional_linked_list_engine_assert.svh
// Assertion macros shared by the list engine
`ifndef POSITIONAL_LINKED_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LINKED_LIST_ENGINE_ASSERT_SVH

// cond holds at every edge out of reset
`define PLL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define PLL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons holds in the cycle after ante
`define PLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pll_pkg.sv
`default_nettype none

package pll_pkg;

    localparam int CAPACITY_DEFAULT = 32;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd5;
    localparam logic [OP_W-1:0] OP_READ     = 3'd6;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
        logic signed [VALUE_W-1:0] element;
        logic                      element_valid;
        logic                      last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/pll_req_if.sv
`default_nettype none

interface pll_req_if;
    import pll_pkg::*;

    logic     valid;
    logic     ready;
    t_request payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/pll_res_if.sv
`default_nettype none

interface pll_res_if;
    import pll_pkg::*;

    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/positional_linked_list_engine.sv
// Channel   Dir  Payload                                         Handshake
// i_req     in   operation, value, position                      valid/ready
// o_res     out  status, count, element, element_valid, last     valid/ready
//
// One request at a time, paced by the single read port of the node memory. Head
// operations and a tail insert need no walk; a middle insert or delete walks pos-2
// link hops from the head, a tail delete walks count-2 hops (none for a lone element),
// and a read-out returns one result per element. Ignored or full requests touch no memory.
// Reset clears head, tail, count and the slot counters; the memories are not swept.
// A stalled o_res holds the engine; a held result does not block the next request.
`default_nettype none

module positional_linked_list_engine #(
    parameter int CAPACITY = pll_pkg::CAPACITY_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pll_req_if.sink   i_req,
    pll_res_if.source o_res
);
    import pll_pkg::*;

    logic    res_valid;
    t_result res;
    logic    res_ready;
    logic    r_out_valid;
    t_result r_out;

    pll_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // advance when the output register is empty or being drained
    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

`default_nettype wire

// File: rtl/pll_ram.sv
`default_nettype none

module pll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/pll_ctrl.sv
`default_nettype none

module pll_ctrl #(
    parameter int CAPACITY = pll_pkg::CAPACITY_DEFAULT
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    pll_req_if.sink        i_req,
    output logic           o_res_valid,
    output pll_pkg::t_result o_res,
    input  wire logic      i_res_ready
);
    import pll_pkg::*;

    `include "positional_linked_list_engine_assert.svh"

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = VALUE_W + SW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_NODE_RD,
        S_NODE_W,
        S_LINK_W,
        S_ALLOC,
        S_ALLOC_W,
        S_W_PRED,
        S_W_NEW,
        S_RELEASE,
        S_REPORT,
        S_OUT_W
    } t_state;

    typedef enum logic [2:0] {
        P_INS_HEAD,
        P_INS_TAIL,
        P_INS_MID,
        P_DEL_HEAD,
        P_DEL_ONE,
        P_DEL_TAIL,
        P_DEL_MID
    } t_plan;

    t_state                    r_state, n_state;
    t_plan                     r_plan, n_plan;
    logic [OP_W-1:0]           r_op, n_op;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic [SW-1:0]             r_head, n_head;
    logic [SW-1:0]             r_tail, n_tail;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_free_top, n_free_top;
    logic [CW-1:0]             r_fresh, n_fresh;
    logic [SW-1:0]             r_cur, n_cur;
    logic [CW-1:0]             r_left, n_left;
    logic [SW-1:0]             r_slot, n_slot;
    logic [VALUE_W-1:0]        r_pval, n_pval;
    logic [SW-1:0]             r_plink, n_plink;
    logic [SW-1:0]             r_newlink, n_newlink;

    logic          node_we, node_re;
    logic [SW-1:0] node_waddr, node_raddr;
    logic [NW-1:0] node_wdata, node_rdata;
    logic          free_we, free_re;
    logic [SW-1:0] free_waddr, free_raddr;
    logic [SW-1:0] free_wdata, free_rdata;

    logic [VALUE_W-1:0] rd_value;
    logic [SW-1:0]      rd_link;
    logic [CW-1:0]      free_dec;
    logic               full, cnt_zero, cnt_one;
    logic [POS_W:0]     pos_ext, cnt_ext;
    logic               pos_zero, pos_one, pos_gt_cnt, pos_gt_cnt1, pos_eq_cnt, pos_eq_cnt1;
    logic [CW-1:0]      pos_steps, tail_steps;
    logic [CW:0]        slot_sum;

    logic          v_walk;
    logic [CW-1:0] v_steps;

    pll_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    pll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (free_waddr),
        .i_wdata (free_wdata),
        .i_re    (free_re),
        .i_raddr (free_raddr),
        .o_rdata (free_rdata)
    );

    assign rd_value    = node_rdata[NW-1:SW];
    assign rd_link     = node_rdata[SW-1:0];
    assign free_dec    = r_free_top - CW'(1);
    assign full        = r_count >= CW'(CAPACITY);
    assign cnt_zero    = r_count == '0;
    assign cnt_one     = r_count == CW'(1);
    assign pos_ext     = {1'b0, r_pos};
    assign cnt_ext     = (POS_W+1)'(r_count);
    assign pos_zero    = r_pos == '0;
    assign pos_one     = r_pos == POS_W'(1);
    assign pos_gt_cnt  = pos_ext > cnt_ext;
    assign pos_eq_cnt  = pos_ext == cnt_ext;
    assign pos_gt_cnt1 = pos_ext > (cnt_ext + (POS_W+1)'(1));
    assign pos_eq_cnt1 = pos_ext == (cnt_ext + (POS_W+1)'(1));
    assign pos_steps   = CW'(r_pos - POS_W'(2));
    assign tail_steps  = r_count - CW'(2);
    assign slot_sum    = (CW+1)'(r_count) + (CW+1)'(r_free_top);

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_plan    = r_plan;
        n_op      = r_op;
        n_value   = r_value;
        n_pos     = r_pos;
        n_status  = r_status;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_free_top = r_free_top;
        n_fresh   = r_fresh;
        n_cur     = r_cur;
        n_left    = r_left;
        n_slot    = r_slot;
        n_pval    = r_pval;
        n_plink   = r_plink;
        n_newlink = r_newlink;

        node_we    = 1'b0;
        node_waddr = r_slot;
        node_wdata = {r_value, r_newlink};
        node_re    = 1'b0;
        node_raddr = r_cur;
        free_we    = 1'b0;
        free_waddr = r_free_top[SW-1:0];
        free_wdata = r_slot;
        free_re    = 1'b0;
        free_raddr = free_dec[SW-1:0];

        o_res_valid         = 1'b0;
        o_res.status        = r_status;
        o_res.count         = COUNT_W'(r_count);
        o_res.element       = '0;
        o_res.element_valid = 1'b0;
        o_res.last          = 1'b1;

        v_walk  = 1'b0;
        v_steps = pos_steps;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.payload.operation;
                    n_value = i_req.payload.value;
                    n_pos   = i_req.payload.position;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_status = ST_DONE;
                n_state  = S_REPORT;
                unique case (r_op)
                    OP_INS_HEAD: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_plan    = P_INS_HEAD;
                            n_newlink = r_head;
                            n_state   = S_ALLOC;
                        end
                    end
                    OP_INS_TAIL: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else if (cnt_zero) begin
                            // the sole node's link is never followed
                            n_plan    = P_INS_HEAD;
                            n_newlink = r_head;
                            n_state   = S_ALLOC;
                        end else begin
                            n_plan  = P_INS_TAIL;
                            n_cur   = r_tail;
                            n_state = S_NODE_RD;
                        end
                    end
                    OP_INS_POS: begin
                        if (pos_zero || pos_gt_cnt1) begin
                            n_status = ST_IGNORED;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else if (pos_one) begin
                            n_plan    = P_INS_HEAD;
                            n_newlink = r_head;
                            n_state   = S_ALLOC;
                        end else if (pos_eq_cnt1) begin
                            n_plan  = P_INS_TAIL;
                            n_cur   = r_tail;
                            n_state = S_NODE_RD;
                        end else begin
                            n_plan  = P_INS_MID;
                            v_walk  = 1'b1;
                            v_steps = pos_steps;
                        end
                    end
                    OP_DEL_HEAD: begin
                        if (cnt_zero) begin
                            n_status = ST_IGNORED;
                        end else begin
                            n_plan  = P_DEL_HEAD;
                            n_cur   = r_head;
                            n_state = S_NODE_RD;
                        end
                    end
                    OP_DEL_TAIL: begin
                        if (cnt_zero) begin
                            n_status = ST_IGNORED;
                        end else if (cnt_one) begin
                            n_plan  = P_DEL_ONE;
                            n_slot  = r_head;
                            n_state = S_RELEASE;
                        end else begin
                            n_plan  = P_DEL_TAIL;
                            n_slot  = r_tail;
                            v_walk  = 1'b1;
                            v_steps = tail_steps;
                        end
                    end
                    OP_DEL_POS: begin
                        if (pos_zero || pos_gt_cnt) begin
                            n_status = ST_IGNORED;
                        end else if (pos_one) begin
                            n_plan  = P_DEL_HEAD;
                            n_cur   = r_head;
                            n_state = S_NODE_RD;
                        end else if (pos_eq_cnt) begin
                            n_plan  = P_DEL_TAIL;
                            n_slot  = r_tail;
                            v_walk  = 1'b1;
                            v_steps = tail_steps;
                        end else begin
                            n_plan  = P_DEL_MID;
                            v_walk  = 1'b1;
                            v_steps = pos_steps;
                        end
                    end
                    OP_READ: begin
                        if (!cnt_zero) begin
                            n_cur      = r_head;
                            n_left     = r_count;
                            node_re    = 1'b1;
                            node_raddr = r_head;
                            n_state    = S_OUT_W;
                        end
                    end
                    default: begin
                        n_status = ST_IGNORED;
                    end
                endcase

                // start the walk from the head towards the predecessor
                if (v_walk) begin
                    n_cur  = r_head;
                    n_left = v_steps;
                    if (v_steps == '0) begin
                        n_state = (n_plan == P_DEL_TAIL) ? S_RELEASE : S_NODE_RD;
                    end else begin
                        node_re    = 1'b1;
                        node_raddr = r_head;
                        n_state    = S_WALK;
                    end
                end
            end

            S_WALK: begin
                n_cur = rd_link;
                if (r_left == CW'(1)) begin
                    n_state = (r_plan == P_DEL_TAIL) ? S_RELEASE : S_NODE_RD;
                end else begin
                    n_left     = r_left - CW'(1);
                    node_re    = 1'b1;
                    node_raddr = rd_link;
                end
            end

            S_NODE_RD: begin
                node_re    = 1'b1;
                node_raddr = r_cur;
                n_state    = S_NODE_W;
            end

            S_NODE_W: begin
                n_pval  = rd_value;
                n_plink = rd_link;
                unique case (r_plan)
                    P_INS_TAIL: begin
                        n_newlink = '0;
                        n_state   = S_ALLOC;
                    end
                    P_INS_MID: begin
                        n_newlink = rd_link;
                        n_state   = S_ALLOC;
                    end
                    P_DEL_HEAD: begin
                        n_head  = rd_link;
                        n_slot  = r_cur;
                        n_state = S_RELEASE;
                    end
                    P_DEL_MID: begin
                        // fetch the victim to learn its successor
                        n_slot     = rd_link;
                        node_re    = 1'b1;
                        node_raddr = rd_link;
                        n_state    = S_LINK_W;
                    end
                    default: begin
                        n_state = S_REPORT;
                    end
                endcase
            end

            S_LINK_W: begin
                n_plink = rd_link;
                n_state = S_W_PRED;
            end

            S_ALLOC: begin
                if (r_free_top != '0) begin
                    free_re = 1'b1;
                    n_state = S_ALLOC_W;
                end else begin
                    n_slot  = r_fresh[SW-1:0];
                    n_plink = r_fresh[SW-1:0];
                    n_fresh = r_fresh + CW'(1);
                    n_state = (r_plan == P_INS_HEAD) ? S_W_NEW : S_W_PRED;
                end
            end

            S_ALLOC_W: begin
                n_slot     = free_rdata;
                n_plink    = free_rdata;
                n_free_top = free_dec;
                n_state    = (r_plan == P_INS_HEAD) ? S_W_NEW : S_W_PRED;
            end

            S_W_PRED: begin
                node_we    = 1'b1;
                node_waddr = r_cur;
                node_wdata = {r_pval, r_plink};
                n_state    = (r_plan == P_DEL_MID) ? S_RELEASE : S_W_NEW;
            end

            S_W_NEW: begin
                node_we    = 1'b1;
                node_waddr = r_slot;
                node_wdata = {r_value, r_newlink};
                n_count    = r_count + CW'(1);
                if (r_plan == P_INS_HEAD) begin
                    n_head = r_slot;
                    if (cnt_zero) begin
                        n_tail = r_slot;
                    end
                end else if (r_plan == P_INS_TAIL) begin
                    n_tail = r_slot;
                end
                n_state = S_REPORT;
            end

            S_RELEASE: begin
                if (r_free_top < CW'(CAPACITY)) begin
                    free_we    = 1'b1;
                    free_waddr = r_free_top[SW-1:0];
                    free_wdata = r_slot;
                    n_free_top = r_free_top + CW'(1);
                end
                n_count = r_count - CW'(1);
                if (r_plan == P_DEL_TAIL) begin
                    n_tail = r_cur;
                end
                n_state = S_REPORT;
            end

            S_REPORT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            S_OUT_W: begin
                o_res_valid         = 1'b1;
                o_res.status        = ST_DONE;
                o_res.element       = rd_value;
                o_res.element_valid = 1'b1;
                o_res.last          = (r_left == CW'(1));
                // hold the node data until the result is taken
                if (i_res_ready) begin
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_left     = r_left - CW'(1);
                        n_cur      = rd_link;
                        node_re    = 1'b1;
                        node_raddr = rd_link;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_plan    <= n_plan;
        r_op      <= n_op;
        r_value   <= n_value;
        r_pos     <= n_pos;
        r_status  <= n_status;
        r_cur     <= n_cur;
        r_left    <= n_left;
        r_slot    <= n_slot;
        r_pval    <= n_pval;
        r_plink   <= n_plink;
        r_newlink <= n_newlink;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_free_top <= '0;
            r_fresh    <= '0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_free_top <= n_free_top;
            r_fresh    <= n_fresh;
        end
    end

    `PLL_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count beyond capacity")
    `PLL_ASSERT_IMPLIES(a_slot_balance, i_clk, i_rst_n, r_state == S_IDLE, slot_sum == (CW+1)'(r_fresh), "slots lost or duplicated")
    `PLL_ASSERT_IMPLIES(a_stack_room, i_clk, i_rst_n, r_state == S_RELEASE, r_free_top < CW'(CAPACITY), "free stack full on release")
    `PLL_ASSERT_NEXT(a_req_dispatch, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == S_DISPATCH, "request not dispatched")
    `PLL_ASSERT_NEXT(a_last_ends_item, i_clk, i_rst_n, o_res_valid && i_res_ready && o_res.last, r_state == S_IDLE, "engine busy after last result")

endmodule

`default_nettype wire
